FILE: design/eased_rgba_color_interpolator_assert.svh
// Assertion helpers for the color interpolator.
`ifndef EASED_RGBA_COLOR_INTERPOLATOR_ASSERT_SVH
`define EASED_RGBA_COLOR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ERCI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ERCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/erci_pkg.sv
package erci_pkg;

  localparam int POSITION_FRAC_BITS_DEF = 14;

  localparam logic signed [31:0] Q_ONE  = 32'sd65536;
  localparam logic signed [31:0] X_LIM  = 32'sd131072;
  localparam logic [16:0]        F_ONE  = 17'h10000;
  localparam logic [16:0]        F_ZERO = 17'h00000;

  localparam logic [3:0] CURVE_NEAREST    = 4'd0;
  localparam logic [3:0] CURVE_LINEAR     = 4'd1;
  localparam logic [3:0] CURVE_SQUARE     = 4'd2;
  localparam logic [3:0] CURVE_INVSQUARE  = 4'd3;
  localparam logic [3:0] CURVE_INVCUBE    = 4'd4;
  localparam logic [3:0] CURVE_INVQUARTIC = 4'd5;
  localparam logic [3:0] CURVE_CUBE       = 4'd6;
  localparam logic [3:0] CURVE_QUARTIC    = 4'd7;
  localparam logic [3:0] CURVE_SMOOTH3    = 4'd8;
  localparam logic [3:0] CURVE_SMOOTH5    = 4'd9;
  localparam logic [3:0] CURVE_SMOOTH7    = 4'd10;
  localparam logic [3:0] CURVE_SMOOTH9    = 4'd11;

  // channels from the lowest byte up: red, green, blue, alpha
  typedef logic [3:0][7:0] rgba_t;

  // clamp a Q.16 value to 0..1 as Q1.16
  function automatic logic [16:0] clamp_unit(input logic signed [39:0] v);
    logic [16:0] r;
    if (v < 40'sd0) begin
      r = F_ZERO;
    end else if (v > 40'sd65536) begin
      r = F_ONE;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  // start + floor((end - start) * f), modulo 256
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [16:0] f);
    logic signed [8:0]  d;
    logic signed [26:0] p;
    logic [10:0]        s;
    d = signed'({1'b0, b}) - signed'({1'b0, a});
    p = d * signed'({1'b0, f});
    s = p[26:16];
    return a + s[7:0];
  endfunction

endpackage

FILE: design/eased_rgba_color_interpolator.sv
// Throughput: one item per cycle unless the output stalls; seven register stages, each with a valid bit,
// and a ready chain that fills bubbles.
// A stalled output holds its stage; earlier stages keep accepting until full.
// Reset: rst (synchronous) clears all valid bits; payload registers are not reset.
module eased_rgba_color_interpolator
  import erci_pkg::*;
#(
  parameter int POSITION_FRAC_BITS = POSITION_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position[15:0], start_red, start_green, start_blue, start_alpha,
  // end_red, end_green, end_blue, end_alpha (8 bits each from bit 16 up)
  input  logic [79:0] s_axis_tdata,
  // curve[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [31:0] m_axis_tdata
);

  localparam int NST = 7;
  localparam int LSH = (POSITION_FRAC_BITS < 16) ? 16 - POSITION_FRAC_BITS : 0;
  localparam int RSH = (POSITION_FRAC_BITS > 16) ? POSITION_FRAC_BITS - 16 : 0;

  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !vld[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: position to Q.16, saturate, linear terms
  logic signed [31:0] pos_w;
  logic signed [31:0] xs;
  always_comb begin
    pos_w = (32'(signed'(s_axis_tdata[15:0])) <<< LSH) >>> RSH;
    if (pos_w > X_LIM) begin
      xs = X_LIM;
    end else if (pos_w < -X_LIM) begin
      xs = -X_LIM;
    end else begin
      xs = pos_w;
    end
  end

  logic        [3:0]  curve1;
  rgba_t              st1, en1;
  logic signed [18:0] x1, u1;
  logic signed [19:0] a3_1;
  logic signed [21:0] a5_1;
  logic signed [23:0] a7_1;
  logic signed [25:0] a9_1;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      curve1 <= s_axis_tuser;
      st1    <= s_axis_tdata[47:16];
      en1    <= s_axis_tdata[79:48];
      x1     <= xs[18:0];
      u1     <= 19'(Q_ONE - xs);
      a3_1   <= 20'(3 * Q_ONE - (xs <<< 1));
      a5_1   <= 22'(6 * xs - 15 * Q_ONE);
      a7_1   <= 24'(70 * Q_ONE - 20 * xs);
      a9_1   <= 26'(70 * xs - 315 * Q_ONE);
    end
  end

  // stage 2: first products
  logic signed [37:0] sq_p, uu_p;
  logic signed [40:0] p5_p;
  logic signed [42:0] p7_p;
  logic signed [44:0] p9_p;
  assign sq_p = x1 * x1;
  assign uu_p = u1 * u1;
  assign p5_p = a5_1 * x1;
  assign p7_p = x1 * a7_1;
  assign p9_p = x1 * a9_1;

  logic        [3:0]  curve2;
  rgba_t              st2, en2;
  logic signed [18:0] x2, u2;
  logic signed [19:0] a3_2, xx2;
  logic signed [20:0] uu2;
  logic signed [22:0] p5a2;
  logic signed [24:0] p7a2;
  logic signed [26:0] p9a2;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      curve2 <= curve1;
      st2    <= st1;
      en2    <= en1;
      x2     <= x1;
      u2     <= u1;
      a3_2   <= a3_1;
      xx2    <= sq_p[35:16];
      uu2    <= uu_p[36:16];
      p5a2   <= p5_p[38:16];
      p7a2   <= p7_p[40:16];
      p9a2   <= p9_p[42:16];
    end
  end

  // stage 3: powers, order 3, inner steps of orders 7 and 9
  logic signed [38:0] x3_p;
  logic signed [39:0] x4_p, u3_p, s3_p;
  logic signed [41:0] u4_p;
  logic signed [25:0] d7;
  logic signed [44:0] p7b_p;
  logic signed [27:0] e9;
  logic signed [46:0] p9b_p;
  assign x3_p  = xx2 * x2;
  assign x4_p  = xx2 * xx2;
  assign u3_p  = uu2 * u2;
  assign u4_p  = uu2 * uu2;
  assign s3_p  = xx2 * a3_2;
  assign d7    = 26'(p7a2) - 26'sd5505024;
  assign p7b_p = x2 * d7;
  assign e9    = 28'(p9a2) + 28'sd35389440;
  assign p9b_p = x2 * e9;

  logic        [3:0]  curve3;
  rgba_t              st3, en3;
  logic signed [18:0] x3;
  logic signed [19:0] xx3;
  logic signed [20:0] uu3, xxx3;
  logic signed [21:0] x4_3, u3_3, s3_3;
  logic signed [23:0] u4_3, t5_3;
  logic signed [26:0] p7b3;
  logic signed [28:0] p9b3;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      curve3 <= curve2;
      st3    <= st2;
      en3    <= en2;
      x3     <= x2;
      xx3    <= xx2;
      uu3    <= uu2;
      xxx3   <= x3_p[36:16];
      x4_3   <= x4_p[37:16];
      u3_3   <= u3_p[37:16];
      u4_3   <= u4_p[39:16];
      s3_3   <= s3_p[37:16];
      t5_3   <= 24'(p5a2) + 24'sd655360;
      p7b3   <= p7b_p[42:16];
      p9b3   <= p9b_p[44:16];
    end
  end

  // stage 4: factor for the short curves, products of orders 5 and 7, x^5
  logic signed [44:0] s5_p;
  logic signed [26:0] t7;
  logic signed [48:0] s7_p;
  logic signed [40:0] x5_p;
  logic signed [28:0] g9;
  logic signed [47:0] p9c_p;
  logic        [16:0] fa_next;
  assign s5_p  = xxx3 * t5_3;
  assign t7    = p7b3 + 27'sd2293760;
  assign s7_p  = x4_3 * t7;
  assign x5_p  = x4_3 * x3;
  assign g9    = 29'(p9b3) - 29'sd27525120;
  assign p9c_p = x3 * g9;

  always_comb begin
    unique case (curve3)
      CURVE_NEAREST:    fa_next = (x3 >= 19'sd32768) ? F_ONE : F_ZERO;
      CURVE_SQUARE:     fa_next = clamp_unit(40'(xx3));
      CURVE_INVSQUARE:  fa_next = clamp_unit(40'sd65536 - 40'(uu3));
      CURVE_INVCUBE:    fa_next = clamp_unit(40'sd65536 - 40'(u3_3));
      CURVE_INVQUARTIC: fa_next = clamp_unit(40'sd65536 - 40'(u4_3));
      CURVE_CUBE:       fa_next = clamp_unit(40'(xxx3));
      CURVE_QUARTIC:    fa_next = clamp_unit(40'(x4_3));
      CURVE_SMOOTH3:    fa_next = clamp_unit(40'(s3_3));
      default:          fa_next = clamp_unit(40'(x3));
    endcase
  end

  logic        [3:0]  curve4;
  rgba_t              st4, en4;
  logic        [16:0] fa4;
  logic signed [26:0] s5_4;
  logic signed [30:0] s7_4;
  logic signed [22:0] x5_4;
  logic signed [29:0] p9c4;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      curve4 <= curve3;
      st4    <= st3;
      en4    <= en3;
      fa4    <= fa_next;
      s5_4   <= s5_p[42:16];
      s7_4   <= s7_p[46:16];
      x5_4   <= x5_p[38:16];
      p9c4   <= p9c_p[45:16];
    end
  end

  // stage 5: orders 5 and 7 done, last inner step of order 9
  logic        [16:0] fb_next;

  always_comb begin
    priority if (curve4 == CURVE_SMOOTH5) begin
      fb_next = clamp_unit(40'(s5_4));
    end else if (curve4 == CURVE_SMOOTH7) begin
      fb_next = clamp_unit(40'(s7_4));
    end else begin
      fb_next = fa4;
    end
  end

  logic        [3:0]  curve5;
  rgba_t              st5, en5;
  logic        [16:0] fb5;
  logic signed [22:0] x5_5;
  logic signed [29:0] t9_5;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      curve5 <= curve4;
      st5    <= st4;
      en5    <= en4;
      fb5    <= fb_next;
      x5_5   <= x5_4;
      t9_5   <= p9c4 + 30'sd8257536;
    end
  end

  // stage 6: order 9 product, final factor
  logic signed [52:0] s9_p;
  logic signed [36:0] s9;
  assign s9_p = x5_5 * t9_5;
  assign s9   = s9_p[52:16];

  rgba_t       st6, en6;
  logic [16:0] f6;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      st6 <= st5;
      en6 <= en5;
      f6  <= (curve5 == CURVE_SMOOTH9) ? clamp_unit(40'(s9)) : fb5;
    end
  end

  // stage 7: channel blend into the output register
  rgba_t out7;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int c = 0; c < 4; c++) begin
        out7[c] <= blend(st6[c], en6[c], f6);
      end
    end
  end

  assign m_axis_tdata = out7;

`include "eased_rgba_color_interpolator_assert.svh"

  `ERCI_ASSERT_NOW(a_factor_range, vld[5], f6 <= F_ONE, "factor above one")
  `ERCI_ASSERT_NOW(a_nearest_step, vld[3] && curve4 == CURVE_NEAREST, fa4 == F_ONE || fa4 == F_ZERO, "nearest factor not a step")
  `ERCI_ASSERT_NEXT(a_full_end, vld[5] && rdy[6] && f6 == F_ONE, m_axis_tdata == $past(en6), "factor one must give end color")
  `ERCI_ASSERT_NEXT(a_zero_start, vld[5] && rdy[6] && f6 == F_ZERO, m_axis_tdata == $past(st6), "factor zero must give start color")

endmodule
